[hw/rtl/mlh_pkg.sv]
// ----------------------------------------------------------------------------
// mlh_pkg: shared types and tables of the markdown line to HTML converter
// Holds the command format passed from the classifier to the byte emitter,
// the tag segment list, and the tables that expand a segment into bytes.
// ----------------------------------------------------------------------------
package mlh_pkg;

  localparam int unsigned MAX_LINE    = 1024;
  localparam int unsigned COL_W       = $clog2(MAX_LINE);
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS);
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned PTR_W       = $clog2(FIFO_DEPTH);
  localparam int unsigned NSEG        = 11;
  localparam int unsigned SEG_W       = $clog2(NSEG);
  localparam int unsigned OFF_W       = 3;

  localparam logic [7:0] CH_HASH = "#";
  localparam logic [7:0] CH_STAR = "*";
  localparam logic [7:0] CH_DASH = "-";
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_ZERO = "0";

  // Segments in the order they are emitted within one beat's run
  typedef enum logic [SEG_W-1:0] {
    SEG_P_CLOSE   = 4'd0,
    SEG_UL_CLOSE  = 4'd1,
    SEG_UL_OPEN   = 4'd2,
    SEG_LI_OPEN   = 4'd3,
    SEG_P_OPEN    = 4'd4,
    SEG_H_OPEN    = 4'd5,
    SEG_TEXT      = 4'd6,
    SEG_H_CLOSE   = 4'd7,
    SEG_LI_CLOSE  = 4'd8,
    SEG_UL_CLOSE2 = 4'd9,
    SEG_P_CLOSE2  = 4'd10
  } seg_e;

  typedef enum logic [5:0] {
    MODE_START     = 6'b000001,
    MODE_HASHES    = 6'b000010,
    MODE_HEAD_BODY = 6'b000100,
    MODE_LIST_SKIP = 6'b001000,
    MODE_LIST_BODY = 6'b010000,
    MODE_PARA      = 6'b100000
  } mode_e;

  typedef struct packed {
    logic [NSEG-1:0] segs;
    logic [3:0]      level;
    logic [7:0]      text;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } cmd_push_t;

  function automatic logic [OFF_W-1:0] seg_len(input seg_e s);
    logic [OFF_W-1:0] n;
    unique case (s)
      SEG_P_CLOSE, SEG_P_CLOSE2, SEG_UL_OPEN:                    n = 3'd5;
      SEG_UL_CLOSE, SEG_UL_CLOSE2, SEG_H_CLOSE, SEG_LI_CLOSE:    n = 3'd6;
      SEG_LI_OPEN, SEG_H_OPEN:                                   n = 3'd4;
      SEG_P_OPEN:                                                n = 3'd3;
      SEG_TEXT:                                                  n = 3'd1;
      default:                                                   n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] seg_char(input seg_e s, input logic [OFF_W-1:0] off,
                                          input logic [3:0] lvl, input logic [7:0] txt);
    logic [47:0] str;
    logic [7:0]  c;
    unique case (s)
      SEG_P_CLOSE, SEG_P_CLOSE2:   str = {"</p>", CH_NL, 8'h00};
      SEG_UL_CLOSE, SEG_UL_CLOSE2: str = {"</ul>", CH_NL};
      SEG_UL_OPEN:                 str = {"<ul>", CH_NL, 8'h00};
      SEG_LI_OPEN:                 str = {"<li>", 16'h0000};
      SEG_P_OPEN:                  str = {"<p>", 24'h000000};
      SEG_H_OPEN:                  str = {"<h0>", 16'h0000};
      SEG_H_CLOSE:                 str = {"</h0>", CH_NL};
      SEG_LI_CLOSE:                str = {"</li>", CH_NL};
      default:                     str = 48'h0;
    endcase
    c = str[8*(5-int'(off)) +: 8];
    if (s == SEG_TEXT) begin
      c = txt;
    end else if ((s == SEG_H_OPEN && off == 3'd2) || (s == SEG_H_CLOSE && off == 3'd3)) begin
      c = CH_ZERO + {4'h0, lvl};
    end
    return c;
  endfunction

endpackage

[hw/rtl/mlh_front.sv]
// ----------------------------------------------------------------------------
// mlh_front: line classifier
// Tracks line mode and open tags, turns each accepted beat that yields output into a command.
// ----------------------------------------------------------------------------
module mlh_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                beat_i,
  input  logic                eod_i,
  input  logic [7:0]          char_i,
  output mlh_pkg::cmd_push_t  push_o
);
  import mlh_pkg::*;

  logic             list_q, list_d, para_q, para_d, held_v_q, held_v_d;
  mode_e            mode_q, mode_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [3:0]       lvl_q, lvl_d;
  logic [7:0]       held_q, held_d;

  logic [COL_W:0]   col_next;
  logic             term;
  logic [3:0]       lvl_new;
  logic [NSEG-1:0]  segs;
  logic [7:0]       text;

  always_comb begin
    col_next = {1'b0, col_q} + 1'b1;
    term     = (char_i == CH_NL) || (col_next >= (COL_W+1)'(MAX_LINE - 1));
    list_d   = list_q;
    para_d   = para_q;
    mode_d   = mode_q;
    held_d   = held_q;
    held_v_d = held_v_q;
    lvl_new  = lvl_q;
    segs     = '0;
    text     = char_i;
    if (eod_i) begin
      unique case (mode_q)
        MODE_HASHES: begin
          segs[SEG_H_OPEN]  = 1'b1;
          segs[SEG_H_CLOSE] = 1'b1;
        end
        MODE_HEAD_BODY: segs[SEG_H_CLOSE] = 1'b1;
        MODE_LIST_SKIP, MODE_LIST_BODY: segs[SEG_LI_CLOSE] = 1'b1;
        default: ;
      endcase
      segs[SEG_UL_CLOSE2] = list_q;
      segs[SEG_P_CLOSE2]  = para_q;
      list_d   = 1'b0;
      para_d   = 1'b0;
      mode_d   = MODE_START;
      col_d    = '0;
      lvl_d    = '0;
      held_d   = '0;
      held_v_d = 1'b0;
    end else begin
      unique case (mode_q)
        MODE_START: begin
          if (char_i == CH_HASH) begin
            segs[SEG_P_CLOSE]  = para_q;
            segs[SEG_UL_CLOSE] = list_q;
            para_d  = 1'b0;
            list_d  = 1'b0;
            lvl_new = 4'd1;
            mode_d  = MODE_HASHES;
            segs[SEG_H_OPEN]  = term;
            segs[SEG_H_CLOSE] = term;
          end else if (char_i == CH_STAR || char_i == CH_DASH) begin
            segs[SEG_P_CLOSE]  = para_q;
            segs[SEG_UL_OPEN]  = !list_q;
            segs[SEG_LI_OPEN]  = 1'b1;
            segs[SEG_LI_CLOSE] = term;
            para_d = 1'b0;
            list_d = 1'b1;
            mode_d = MODE_LIST_SKIP;
          end else begin
            segs[SEG_UL_CLOSE] = list_q;
            segs[SEG_P_OPEN]   = !para_q;
            list_d = 1'b0;
            para_d = 1'b1;
            if (!term) begin
              held_d   = char_i;
              held_v_d = 1'b1;
              mode_d   = MODE_PARA;
            end
          end
        end
        MODE_HASHES: begin
          if (char_i == CH_HASH) begin
            if (lvl_q < 4'd9) lvl_new = lvl_q + 4'd1;
            segs[SEG_H_OPEN] = term;
          end else begin
            segs[SEG_H_OPEN] = 1'b1;
            mode_d = MODE_HEAD_BODY;
          end
          segs[SEG_H_CLOSE] = term;
        end
        MODE_HEAD_BODY: begin
          segs[SEG_TEXT]    = 1'b1;
          segs[SEG_H_CLOSE] = term;
        end
        MODE_LIST_SKIP: begin
          mode_d = MODE_LIST_BODY;
          segs[SEG_LI_CLOSE] = term;
        end
        MODE_LIST_BODY: begin
          segs[SEG_TEXT]     = 1'b1;
          segs[SEG_LI_CLOSE] = term;
        end
        MODE_PARA: begin
          segs[SEG_TEXT] = held_v_q;
          text = held_q;
          if (!term) begin
            held_d   = char_i;
            held_v_d = 1'b1;
          end
        end
        default: ;
      endcase
      // close the line piece
      if (term || !(mode_q inside {MODE_START, MODE_HASHES, MODE_HEAD_BODY,
                                   MODE_LIST_SKIP, MODE_LIST_BODY, MODE_PARA})) begin
        mode_d   = MODE_START;
        col_d    = '0;
        lvl_d    = '0;
        held_d   = '0;
        held_v_d = 1'b0;
      end else begin
        col_d = col_next[COL_W-1:0];
        lvl_d = lvl_new;
      end
    end
    push_o.push      = beat_i && (|segs);
    push_o.cmd.segs  = segs;
    push_o.cmd.level = lvl_new;
    push_o.cmd.text  = text;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_q   <= 1'b0;
      para_q   <= 1'b0;
      mode_q   <= MODE_START;
      col_q    <= '0;
      lvl_q    <= '0;
      held_q   <= '0;
      held_v_q <= 1'b0;
    end else if (beat_i) begin
      list_q   <= list_d;
      para_q   <= para_d;
      mode_q   <= mode_d;
      col_q    <= col_d;
      lvl_q    <= lvl_d;
      held_q   <= held_d;
      held_v_q <= held_v_d;
    end
  end

endmodule

[hw/rtl/mlh_fifo.sv]
// ----------------------------------------------------------------------------
// mlh_fifo: command queue
// Short queue of commands between the classifier and the byte emitter.
// ----------------------------------------------------------------------------
module mlh_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mlh_pkg::cmd_push_t push_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               empty_o,
  output mlh_pkg::cmd_t      head_o
);
  import mlh_pkg::*;

  cmd_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (PTR_W+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_q] <= push_i.cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i.push) wr_q <= wr_q + 1'b1;
      if (pop_i)       rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PTR_W+1)'(push_i.push) - (PTR_W+1)'(pop_i);
    end
  end

endmodule

[hw/rtl/mlh_back.sv]
// ----------------------------------------------------------------------------
// mlh_back: byte emitter
// Expands the head command segment by segment, one byte per beat.
// ----------------------------------------------------------------------------
module mlh_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  mlh_pkg::cmd_t      head_i,
  input  logic               ready_i,
  output logic               valid_o,
  output logic [7:0]         byte_o,
  output logic               last_o,
  output logic               pop_o
);
  import mlh_pkg::*;

  logic [NSEG-1:0]  done_q;
  logic [OFF_W-1:0] off_q;
  logic [CNT_W-1:0] cnt_q;

  logic [NSEG-1:0]  rem, cur_hot;
  seg_e             cur;
  logic             seg_end, beat;

  always_comb begin
    rem = head_i.segs & ~done_q;
    cur = SEG_P_CLOSE;
    for (int i = NSEG - 1; i >= 0; i--) begin
      if (rem[i]) cur = seg_e'(i[SEG_W-1:0]);
    end
    cur_hot = NSEG'(1) << cur;
    seg_end = (off_q == seg_len(cur) - 3'd1);
    valid_o = !empty_i;
    byte_o  = seg_char(cur, off_q, head_i.level, head_i.text);
    last_o  = (seg_end && !(|(rem & ~cur_hot))) || (cnt_q == CNT_W'(MAX_RESULTS - 1));
    beat    = valid_o && ready_i;
    pop_o   = beat && last_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= '0;
      off_q  <= '0;
      cnt_q  <= '0;
    end else if (beat) begin
      if (last_o) begin
        done_q <= '0;
        off_q  <= '0;
        cnt_q  <= '0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
        if (seg_end) begin
          done_q <= done_q | cur_hot;
          off_q  <= '0;
        end else begin
          off_q <= off_q + 1'b1;
        end
      end
    end
  end

endmodule

[hw/rtl/markdown_line_to_html_stream_unit.sv]
// ----------------------------------------------------------------------------
// markdown_line_to_html_stream_unit: markdown text to HTML byte stream
// Takes markdown bytes (or an end-of-document mark) and emits HTML bytes.
// ----------------------------------------------------------------------------
// Rate: the input takes one beat per cycle whenever the four-entry command
// queue has room. Each input beat yields a run of 0 to 16 output bytes, and
// the emitter sends one byte per cycle while m_axis_tready is high; tag
// bursts (up to 16 bytes) fill the queue and then hold the input. A beat
// with no result bytes never enters the queue. The last byte of each run is
// flagged with tlast. Lines longer than MAX_LINE-1 bytes are split.
module markdown_line_to_html_stream_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_byte
  input  logic       s_axis_tuser,   // [0] action: 1 = end of document
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast    // last byte of the run for one input beat
);
  import mlh_pkg::*;

  cmd_push_t push;
  cmd_t      head;
  logic      full, empty, pop, s_beat;

  // accept while the queue has room, regardless of the output side
  assign s_axis_tready = !full;
  assign s_beat        = s_axis_tvalid && s_axis_tready;

  // classify the beat and build its tag command
  mlh_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (s_beat),
    .eod_i  (s_axis_tuser),
    .char_i (s_axis_tdata),
    .push_o (push)
  );

  // hold commands so each side can stall independently
  mlh_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  // expand the head command into output bytes
  mlh_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .byte_o  (m_axis_tdata),
    .last_o  (m_axis_tlast),
    .pop_o   (pop)
  );

endmodule

[hw/rtl/mlh_checker.sv]
// ----------------------------------------------------------------------------
// mlh_checker: port-level checks of the converter
// Watches the stream ports over time and reports violations.
// ----------------------------------------------------------------------------
module mlh_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output beat changed");

  a_rst_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_rst_ready: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> s_axis_tready)
    else $error("input not ready right after reset");

endmodule

bind markdown_line_to_html_stream_unit mlh_checker u_mlh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
